@@ rtl/xmps_pkg.sv @@
package xmps_pkg;

  localparam logic [1:0] REQ_HEADER = 2'd0;
  localparam logic [1:0] REQ_BYTE   = 2'd1;
  localparam logic [1:0] REQ_END    = 2'd2;

  localparam logic [1:0] STATUS_COMPLETE   = 2'd0;
  localparam logic [1:0] STATUS_FAILED     = 2'd1;
  localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

  localparam logic [15:0] ID_BEGIN_PART  = 16'd332;
  localparam logic [15:0] ID_END_PART    = 16'd333;
  localparam logic [15:0] ID_BEGIN_TYPES = 16'd334;
  localparam logic [15:0] ID_TYPE_DECL   = 16'd335;
  localparam logic [15:0] ID_END_TYPES   = 16'd336;
  localparam logic [15:0] ID_BEGIN_CELLS = 16'd337;
  localparam logic [15:0] ID_END_CELLS   = 16'd338;
  localparam logic [15:0] ID_CELL_ENTRY  = 16'd51;

  localparam int FL_PART_OPEN    = 0;
  localparam int FL_PART_CLOSED  = 1;
  localparam int FL_IN_TYPES     = 2;
  localparam int FL_TYPES_CLOSED = 3;
  localparam int FL_IN_CELLS     = 4;
  localparam int FL_CELLS_CLOSED = 5;

  localparam logic [27:0] NAME_START  = 28'd12;
  localparam logic [27:0] COUNT_LAST  = 28'd11;
  localparam logic [27:0] FLAGS_BYTES = 28'd8;
  localparam logic [27:0] ENTRY_HDR   = 28'd4;
  localparam logic [31:0] NAME_LEN    = 32'd6;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] record_type;
    logic [27:0] payload_len;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [31:0] cell_meta_index;
    logic [1:0]  scan_status;
  } res_t;

  typedef enum logic [1:0] {
    OP_HEADER,
    OP_BYTE,
    OP_END
  } op_e;

  typedef enum logic [3:0] {
    REC_OTHER,
    REC_BEGIN_PART,
    REC_END_PART,
    REC_BEGIN_TYPES,
    REC_TYPE_DECL,
    REC_END_TYPES,
    REC_BEGIN_CELLS,
    REC_END_CELLS,
    REC_CELL_ENTRY
  } rec_e;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_TYPE,
    KIND_ENTRY
  } kind_e;

  typedef struct packed {
    op_e         op;
    rec_e        rec;
    logic        len_zero;
    logic [27:0] payload_len;
    logic [7:0]  data_byte;
  } cmd_t;

  function automatic logic [7:0] name_char(logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0: c = 8'h58;
      3'd1: c = 8'h4C;
      3'd2: c = 8'h44;
      3'd3: c = 8'h41;
      3'd4: c = 8'h50;
      3'd5: c = 8'h52;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/xlsb_metadata_part_scanner.sv @@
// Metadata-part scanner. Input transactions carry one request each: a record
// header (type and payload length), one payload byte, or an end of buffer.
// Push a transaction with push while full is low; request code 3 is taken
// and dropped. Each end transaction yields exactly one result transaction
// (matching cell-metadata entry index and scan status), read from the result
// side while empty is low and taken with pop. All other requests yield none.
// The block takes one transaction every cycle while full is low. The scanner
// executes a transaction once it reaches the head of the command queue, and
// an end transaction's result is registered in the result queue first.
// The command queue decouples intake from the scanner and the result queue
// decouples the scanner from the reader. When the reader stalls, the scanner
// keeps executing headers and bytes and only holds at an end transaction
// while the result queue is full; full rises once the command queue fills.
// Reset empties both queues and clears all framing flags, counters and
// findings, so the first transaction after reset starts a fresh scan.
module xlsb_metadata_part_scanner import xmps_pkg::*; #(
  parameter int unsigned CMD_DEPTH = 4,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  input  req_t req_i,
  output logic full,
  output logic empty,
  input  logic pop,
  output res_t res_o
);

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_empty, cmd_pop;
  logic res_push, res_full;
  res_t res_in;

  xmps_front u_front (
    .req_i      (req_i),
    .push_i     (push),
    .cmd_o      (cmd_in),
    .cmd_push_o (cmd_push)
  );

  xmps_fifo #(
    .DEPTH (CMD_DEPTH),
    .T     (cmd_t)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  xmps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  xmps_fifo #(
    .DEPTH (RES_DEPTH),
    .T     (res_t)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_o),
    .empty_o (empty)
  );

endmodule

@@ rtl/xmps_fifo.sv @@
module xmps_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  T               mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           push_ok, pop_ok;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(DEPTH))
    else $error("Queue occupancy exceeds its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_ok && !pop_ok) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("Queue occupancy did not grow on a lone write.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_ok && !push_ok) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("Queue occupancy did not shrink on a lone read.");

endmodule

@@ rtl/xmps_front.sv @@
module xmps_front import xmps_pkg::*; (
  input  req_t req_i,
  input  logic push_i,
  output cmd_t cmd_o,
  output logic cmd_push_o
);

  always_comb begin
    cmd_o.payload_len = req_i.payload_len;
    cmd_o.data_byte   = req_i.data_byte;
    cmd_o.len_zero    = (req_i.payload_len == '0);
    cmd_push_o        = push_i;
    case (req_i.req_type)
      REQ_HEADER: cmd_o.op = OP_HEADER;
      REQ_BYTE:   cmd_o.op = OP_BYTE;
      REQ_END:    cmd_o.op = OP_END;
      default: begin
        cmd_o.op   = OP_END;
        cmd_push_o = 1'b0;
      end
    endcase
    case (req_i.record_type)
      ID_BEGIN_PART:  cmd_o.rec = REC_BEGIN_PART;
      ID_END_PART:    cmd_o.rec = REC_END_PART;
      ID_BEGIN_TYPES: cmd_o.rec = REC_BEGIN_TYPES;
      ID_TYPE_DECL:   cmd_o.rec = REC_TYPE_DECL;
      ID_END_TYPES:   cmd_o.rec = REC_END_TYPES;
      ID_BEGIN_CELLS: cmd_o.rec = REC_BEGIN_CELLS;
      ID_END_CELLS:   cmd_o.rec = REC_END_CELLS;
      ID_CELL_ENTRY:  cmd_o.rec = REC_CELL_ENTRY;
      default:        cmd_o.rec = REC_OTHER;
    endcase
  end

endmodule

@@ rtl/xmps_back.sv @@
module xmps_back import xmps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_empty_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  logic [5:0]  flags_q, flags_d;
  logic        failed_q, failed_d;
  logic [31:0] type_cnt_q, type_cnt_d;
  logic [31:0] entry_cnt_q, entry_cnt_d;
  logic [31:0] found_type_q, found_type_d;
  logic [31:0] found_entry_q, found_entry_d;
  kind_e       kind_q, kind_d;
  logic [27:0] left_q, left_d;
  logic [27:0] pos_q, pos_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] count_q, count_d;
  logic        match_q, match_d;

  logic [31:0] acc_next;
  logic [27:0] q;
  logic [7:0]  want;
  logic        early;
  logic        check;
  logic        framed;

  assign framed = flags_q[FL_PART_OPEN] && flags_q[FL_PART_CLOSED] &&
                  flags_q[FL_TYPES_CLOSED] && flags_q[FL_CELLS_CLOSED] &&
                  !flags_q[FL_IN_TYPES] && !flags_q[FL_IN_CELLS];

  always_comb begin
    flags_d       = flags_q;
    failed_d      = failed_q;
    type_cnt_d    = type_cnt_q;
    entry_cnt_d   = entry_cnt_q;
    found_type_d  = found_type_q;
    found_entry_d = found_entry_q;
    kind_d        = kind_q;
    left_d        = left_q;
    pos_d         = pos_q;
    acc_d         = acc_q;
    count_d       = count_q;
    match_d       = match_q;
    acc_next      = {cmd_i.data_byte, acc_q[31:8]};
    q             = '0;
    want          = '0;
    early         = 1'b0;
    check         = 1'b0;
    res_push_o    = 1'b0;
    res_o.cell_meta_index = '0;
    res_o.scan_status     = STATUS_INCOMPLETE;
    cmd_pop_o = !cmd_empty_i && (cmd_i.op != OP_END || !res_full_i);

    if (cmd_pop_o) begin
      case (cmd_i.op)
        OP_HEADER: begin
          if (!failed_q) begin
            if (left_q != '0) begin
              failed_d = 1'b1;
            end else begin
              kind_d  = KIND_SKIP;
              pos_d   = '0;
              count_d = '0;
              match_d = 1'b1;
              case (cmd_i.rec)
                REC_BEGIN_PART:  flags_d[FL_PART_OPEN] = 1'b1;
                REC_END_PART:    flags_d[FL_PART_CLOSED] = 1'b1;
                REC_BEGIN_TYPES: flags_d[FL_IN_TYPES] = 1'b1;
                REC_END_TYPES: begin
                  flags_d[FL_IN_TYPES]     = 1'b0;
                  flags_d[FL_TYPES_CLOSED] = 1'b1;
                end
                REC_BEGIN_CELLS: begin
                  if (!flags_q[FL_TYPES_CLOSED]) begin
                    early = 1'b1;
                  end else begin
                    flags_d[FL_IN_CELLS] = 1'b1;
                  end
                end
                REC_END_CELLS: begin
                  flags_d[FL_IN_CELLS]     = 1'b0;
                  flags_d[FL_CELLS_CLOSED] = 1'b1;
                end
                REC_TYPE_DECL: begin
                  if (flags_q[FL_IN_TYPES]) begin
                    type_cnt_d = type_cnt_q + 1'b1;
                    kind_d     = KIND_TYPE;
                  end
                end
                REC_CELL_ENTRY: begin
                  if (flags_q[FL_IN_CELLS]) begin
                    entry_cnt_d = entry_cnt_q + 1'b1;
                    kind_d      = KIND_ENTRY;
                  end
                end
                default: begin
                end
              endcase
              if (early || (cmd_i.len_zero && kind_d != KIND_SKIP)) begin
                failed_d = 1'b1;
              end else begin
                left_d = cmd_i.payload_len;
              end
            end
          end
        end
        OP_BYTE: begin
          if (!failed_q) begin
            if (left_q == '0) begin
              failed_d = 1'b1;
            end else begin
              case (kind_q)
                KIND_TYPE: begin
                  if (pos_q >= FLAGS_BYTES) begin
                    if (pos_q < NAME_START) begin
                      acc_d = acc_next;
                      if (pos_q == COUNT_LAST) begin
                        count_d = acc_next;
                        match_d = (acc_next == NAME_LEN);
                        check   = 1'b1;
                      end
                    end else begin
                      q     = pos_q - NAME_START;
                      want  = q[0] ? 8'h00 : name_char(q[3:1]);
                      check = 1'b1;
                      if (match_q && (q >= NAME_START || cmd_i.data_byte != want)) begin
                        match_d = 1'b0;
                      end
                    end
                    if (check && ({5'b0, pos_q - COUNT_LAST} == {count_d, 1'b0})) begin
                      if (match_d && found_type_q == '0) begin
                        found_type_d = type_cnt_q;
                      end
                      kind_d = KIND_SKIP;
                    end
                  end
                end
                KIND_ENTRY: begin
                  acc_d = acc_next;
                  if (pos_q < ENTRY_HDR) begin
                    if (pos_q == ENTRY_HDR - 1'b1) begin
                      count_d = acc_next;
                      if (acc_next == '0) begin
                        kind_d = KIND_SKIP;
                      end
                    end
                  end else begin
                    q = pos_q - ENTRY_HDR;
                    if (q[2:0] == 3'd3) begin
                      if (found_entry_q == '0 && found_type_q != '0 &&
                          acc_next == found_type_q) begin
                        found_entry_d = entry_cnt_q;
                      end
                    end else if (q[2:0] == 3'd7) begin
                      if (32'(q[27:3]) + 32'd1 == count_q) begin
                        kind_d = KIND_SKIP;
                      end
                    end
                  end
                end
                default: begin
                end
              endcase
              pos_d  = pos_q + 1'b1;
              left_d = left_q - 1'b1;
              if (left_d == '0 && kind_d != KIND_SKIP) begin
                failed_d = 1'b1;
              end
            end
          end
        end
        OP_END: begin
          res_push_o = 1'b1;
          if (failed_q || left_q != '0) begin
            res_o.scan_status = STATUS_FAILED;
          end else if (framed) begin
            res_o.cell_meta_index = found_entry_q;
            res_o.scan_status     = STATUS_COMPLETE;
          end
          flags_d       = '0;
          failed_d      = 1'b0;
          type_cnt_d    = '0;
          entry_cnt_d   = '0;
          found_type_d  = '0;
          found_entry_d = '0;
          kind_d        = KIND_SKIP;
          left_d        = '0;
          pos_d         = '0;
          count_d       = '0;
          match_d       = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q       <= '0;
      failed_q      <= 1'b0;
      type_cnt_q    <= '0;
      entry_cnt_q   <= '0;
      found_type_q  <= '0;
      found_entry_q <= '0;
      kind_q        <= KIND_SKIP;
      left_q        <= '0;
      pos_q         <= '0;
      count_q       <= '0;
      match_q       <= 1'b1;
    end else begin
      flags_q       <= flags_d;
      failed_q      <= failed_d;
      type_cnt_q    <= type_cnt_d;
      entry_cnt_q   <= entry_cnt_d;
      found_type_q  <= found_type_d;
      found_entry_q <= found_entry_d;
      kind_q        <= kind_d;
      left_q        <= left_d;
      pos_q         <= pos_d;
      count_q       <= count_d;
      match_q       <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_entry_q != '0) |-> (found_type_q != '0))
    else $error("An entry was matched before the wanted type was found.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q != KIND_SKIP && !failed_q) |-> (left_q != '0))
    else $error("A record is still being decoded with no payload owed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (flags_q == '0 && !failed_q && left_q == '0))
    else $error("The scan state was not cleared after a result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.scan_status != STATUS_COMPLETE) |-> (res_o.cell_meta_index == '0))
    else $error("A failed or incomplete scan reported a nonzero index.");

endmodule
